// File: hdl/edal_pkg.sv
// ----------------------------------------------------------------------------
// edal_pkg: shared types and constants of the echo distance average unit
// Holds the field widths, reset values, register indexes, controller states
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package edal_pkg;

  // Window of the moving average; a power of two so the mean is a shift.
  localparam int WINDOW_DEPTH = 8;
  localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int AVG_SHIFT    = $clog2(WINDOW_DEPTH);

  // Field widths.
  localparam int ECHO_W   = 10;
  localparam int SAMPLE_W = 14;
  localparam int LEVEL_W  = 14;
  localparam int SUM_W    = SAMPLE_W + AVG_SHIFT;
  localparam int PROD_W   = SAMPLE_W + LEVEL_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  // Iterative divider: the quotient is known to fit SAMPLE_W bits.
  localparam int DIV_STEPS = SAMPLE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Constants.
  localparam logic [SAMPLE_W-1:0] CM_TO_MM         = SAMPLE_W'(10);
  localparam logic [SAMPLE_W-1:0] RING_RESET_VALUE = SAMPLE_W'(40);
  localparam logic [SUM_W-1:0]    SUM_RESET_VALUE  = SUM_W'(40 * WINDOW_DEPTH);
  localparam logic [LEVEL_W-1:0]  LEVEL_FULL_SCALE = LEVEL_W'(10000);
  localparam logic [SAMPLE_W-1:0] FULL_RESET       = SAMPLE_W'(30);
  localparam logic [SAMPLE_W-1:0] EMPTY_RESET      = SAMPLE_W'(300);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FULL_DISTANCE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_DISTANCE = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_AVERAGE,
    ST_PREP,
    ST_DIV_START,
    ST_DIVIDE,
    ST_WRITE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;
    logic update_ring;
    logic compute_avg;
    logic prep_level;
    logic div_start;
    logic div_step;
    logic load_out;
  } edal_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_last;
  } edal_status_t;

endpackage

`default_nettype wire

// File: hdl/echo_distance_average_level_unit.sv
// ----------------------------------------------------------------------------
// echo_distance_average_level_unit: echo moving average and fill level
// Averages ultrasonic echo distances over an eight-entry window, holding the
// last average through dropouts, and maps the mean to a reservoir fill level.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid/in_ready, echo_cm) takes one distance in cm per
//   transaction; zero means no echo and reuses the previous average.
// - Output channel (out_valid/out_ready) returns average_mm and
//   level_centipercent, one result per input transaction.
// - Configuration: cfg_write with cfg_index 0 sets the full distance and
//   index 1 the empty distance, in mm; write only while the block is idle.
// - From input acceptance to out_valid the controller walks ring update, mean,
//   level setup and a one-bit-per-cycle restoring divider, then loads the
//   output register once it is free.
// - The block takes a new transaction only after loading the last result;
//   in_ready is high only while the controller waits for input.
// - A stalled receiver holds the result in the output register; the block
//   still accepts and processes the next transaction, then waits to load it.
// - Reset fills the ring with 40 mm, clears the held average and restores
//   the thresholds to 30 mm and 300 mm.
// ----------------------------------------------------------------------------
`default_nettype none

module echo_distance_average_level_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [edal_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [edal_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [edal_pkg::ECHO_W-1:0]      echo_cm,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [edal_pkg::SAMPLE_W-1:0]         average_mm,
  output logic [edal_pkg::LEVEL_W-1:0]          level_centipercent
);

  edal_pkg::edal_cmd_t    cmd;
  edal_pkg::edal_status_t status;

  // Sequencing.
  edal_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  edal_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .echo_cm            (echo_cm),
    .cmd                (cmd),
    .status             (status),
    .average_mm         (average_mm),
    .level_centipercent (level_centipercent)
  );

endmodule

`default_nettype wire

// File: hdl/edal_controller.sv
// ----------------------------------------------------------------------------
// edal_controller: sequencing state machine
// Steps one transaction through ring update, averaging, level setup and the
// iterative divide, and owns the input ready and output valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module edal_controller (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire edal_pkg::edal_status_t status,
  output edal_pkg::edal_cmd_t        cmd
);

  edal_pkg::state_t state;
  edal_pkg::state_t state_next;
  logic             out_free;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edal_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The output register is free when empty or being emptied this cycle.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == edal_pkg::ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      edal_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = edal_pkg::ST_UPDATE;
        end
      end
      edal_pkg::ST_UPDATE: begin
        cmd.update_ring = 1'b1;
        state_next      = edal_pkg::ST_AVERAGE;
      end
      edal_pkg::ST_AVERAGE: begin
        cmd.compute_avg = 1'b1;
        state_next      = edal_pkg::ST_PREP;
      end
      edal_pkg::ST_PREP: begin
        cmd.prep_level = 1'b1;
        state_next     = edal_pkg::ST_DIV_START;
      end
      edal_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = edal_pkg::ST_DIVIDE;
      end
      edal_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = edal_pkg::ST_WRITE;
        end
      end
      edal_pkg::ST_WRITE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = edal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = edal_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid flag: set on load, cleared when the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/edal_datapath.sv
// ----------------------------------------------------------------------------
// edal_datapath: sample ring, running sum, level arithmetic and divider
// Holds the configuration registers, the moving average state, a restoring
// divider that yields one quotient bit per cycle, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module edal_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [edal_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [edal_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic [edal_pkg::ECHO_W-1:0]           echo_cm,
  input  wire edal_pkg::edal_cmd_t                   cmd,
  output edal_pkg::edal_status_t                     status,
  output logic [edal_pkg::SAMPLE_W-1:0]              average_mm,
  output logic [edal_pkg::LEVEL_W-1:0]               level_centipercent
);

  logic [edal_pkg::SAMPLE_W-1:0]  full_distance_mm;
  logic [edal_pkg::SAMPLE_W-1:0]  empty_distance_mm;
  logic [edal_pkg::SAMPLE_W-1:0]  sample_ring [edal_pkg::WINDOW_DEPTH];
  logic [edal_pkg::SLOT_W-1:0]    write_slot;
  logic [edal_pkg::SUM_W-1:0]     window_sum;
  logic [edal_pkg::SAMPLE_W-1:0]  held_average;
  logic [edal_pkg::SAMPLE_W-1:0]  reading;
  logic [edal_pkg::SAMPLE_W-1:0]  echo_mm;
  logic [edal_pkg::PROD_W-1:0]    product;
  logic [edal_pkg::SAMPLE_W-1:0]  span;
  logic                           is_full;
  logic                           is_empty;
  logic [edal_pkg::SAMPLE_W-1:0]  rem;
  logic [edal_pkg::SAMPLE_W-1:0]  quot;
  logic [edal_pkg::DIV_CNT_W-1:0] div_count;
  logic [edal_pkg::SAMPLE_W:0]    shifted;
  logic                           fits;
  logic [edal_pkg::SAMPLE_W-1:0]  level_value;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      full_distance_mm  <= edal_pkg::FULL_RESET;
      empty_distance_mm <= edal_pkg::EMPTY_RESET;
    end else if (cfg_write) begin
      if (cfg_index == edal_pkg::REG_FULL_DISTANCE) begin
        full_distance_mm <= cfg_data;
      end
      if (cfg_index == edal_pkg::REG_EMPTY_DISTANCE) begin
        empty_distance_mm <= cfg_data;
      end
    end
  end

  // Scale the echo to millimetres; a missing echo takes the held average.
  assign echo_mm = edal_pkg::SAMPLE_W'(echo_cm) * edal_pkg::CM_TO_MM;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      reading <= (echo_cm == '0) ? held_average : echo_mm;
    end
  end

  // Ring buffer, slot pointer, running sum and held average.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < edal_pkg::WINDOW_DEPTH; i++) begin
        sample_ring[i] <= edal_pkg::RING_RESET_VALUE;
      end
      write_slot   <= '0;
      window_sum   <= edal_pkg::SUM_RESET_VALUE;
      held_average <= '0;
    end else begin
      if (cmd.update_ring) begin
        window_sum              <= window_sum - edal_pkg::SUM_W'(sample_ring[write_slot])
                                   + edal_pkg::SUM_W'(reading);
        sample_ring[write_slot] <= reading;
        if (write_slot == edal_pkg::SLOT_W'(edal_pkg::WINDOW_DEPTH - 1)) begin
          write_slot <= '0;
        end else begin
          write_slot <= write_slot + 1'b1;
        end
      end
      if (cmd.compute_avg) begin
        held_average <= edal_pkg::SAMPLE_W'(window_sum >> edal_pkg::AVG_SHIFT);
      end
    end
  end

  // Threshold tests and the scaled numerator for the linear map.
  always_ff @(posedge clk) begin
    if (cmd.prep_level) begin
      is_full  <= (held_average <= full_distance_mm);
      is_empty <= (held_average >= empty_distance_mm);
      span     <= empty_distance_mm - full_distance_mm;
      product  <= edal_pkg::PROD_W'(empty_distance_mm - held_average)
                  * edal_pkg::PROD_W'(edal_pkg::LEVEL_FULL_SCALE);
    end
  end

  // Restoring divider. The quotient fits SAMPLE_W bits, so the upper half
  // of the numerator starts as the partial remainder.
  assign shifted = {rem, quot[edal_pkg::SAMPLE_W-1]};
  assign fits    = (shifted >= {1'b0, span});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem       <= product[edal_pkg::PROD_W-1:edal_pkg::SAMPLE_W];
      quot      <= product[edal_pkg::SAMPLE_W-1:0];
      div_count <= '0;
    end else if (cmd.div_step) begin
      if (fits) begin
        rem <= edal_pkg::SAMPLE_W'(shifted - {1'b0, span});
      end else begin
        rem <= shifted[edal_pkg::SAMPLE_W-1:0];
      end
      quot      <= {quot[edal_pkg::SAMPLE_W-2:0], fits};
      div_count <= div_count + 1'b1;
    end
  end

  assign status.div_last = (div_count == edal_pkg::DIV_CNT_W'(edal_pkg::DIV_STEPS - 1));

  // Full test wins over the empty test when the thresholds are crossed.
  always_comb begin
    priority if (is_full) begin
      level_value = edal_pkg::LEVEL_FULL_SCALE;
    end else if (is_empty) begin
      level_value = '0;
    end else begin
      level_value = quot;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average_mm         <= held_average;
      level_centipercent <= level_value;
    end
  end

endmodule

`default_nettype wire
